// ===== sv/rs_systematic_encoder_defines.svh =====
// ---------------------------------------------------------------------------
// rs_systematic_encoder_defines: assertion macros for the encoder
// ---------------------------------------------------------------------------
`ifndef RS_SYSTEMATIC_ENCODER_DEFINES_SVH
`define RS_SYSTEMATIC_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// property checked at every rising clk edge outside reset
`define RSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression that must never be true
`define RSE_NEVER(lbl, expr, msg) \
	`RSE_ASSERT(lbl, !(expr), msg)

`else

`define RSE_ASSERT(lbl, prop, msg)
`define RSE_NEVER(lbl, expr, msg)

`endif

`endif

// ===== sv/rse_pkg.sv =====
// ---------------------------------------------------------------------------
// rse_pkg: shared types and constants
// Item structs, cell control, register indexes and reset values.
// ---------------------------------------------------------------------------
package rse_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT = 2'd1;

	localparam logic [7:0] FIELD_POLY_RESET = 8'd29;
	localparam logic [5:0] PARITY_COUNT_RESET = 6'd16;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_symbol;
	} sym_item_t;

	typedef struct packed {
		logic [7:0] code_symbol;
		logic       is_parity;
		logic       last_of_block;
	} code_item_t;

	typedef struct packed {
		logic encode;
		logic shift;
		logic gen_clear;
		logic gen_step;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		GEN_IDLE,
		GEN_CLEAR,
		GEN_STEP
	} gen_state_t;

endpackage

// ===== sv/rse_cell.sv =====
// ---------------------------------------------------------------------------
// rse_cell: one tap of the encoder chain
// Holds one generator coefficient and one remainder symbol, with one
// GF multiplier shared between generator build and encoding.
// ---------------------------------------------------------------------------
module rse_cell
	import rse_pkg::*;
#(
	parameter int SYMBOL_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_ctrl_t             ctrl,
	input  logic [SYMBOL_BITS-1:0] poly,
	input  logic [SYMBOL_BITS-1:0] fb,
	input  logic [SYMBOL_BITS-1:0] alpha,
	input  logic [SYMBOL_BITS-1:0] gen_left,
	input  logic [SYMBOL_BITS-1:0] rem_right,
	output logic [SYMBOL_BITS-1:0] gen,
	output logic [SYMBOL_BITS-1:0] rem
);

	logic [SYMBOL_BITS-1:0] gen_q;
	logic [SYMBOL_BITS-1:0] rem_q;
	logic [SYMBOL_BITS-1:0] mul_a;
	logic [SYMBOL_BITS-1:0] mul_b;
	logic [SYMBOL_BITS-1:0] prod;

	function automatic logic [SYMBOL_BITS-1:0] gf_mul(
		input logic [SYMBOL_BITS-1:0] a_in,
		input logic [SYMBOL_BITS-1:0] b_in,
		input logic [SYMBOL_BITS-1:0] p_in
	);
		logic [SYMBOL_BITS-1:0] a;
		logic [SYMBOL_BITS-1:0] r;
		a = a_in;
		r = '0;
		for (int i = 0; i < SYMBOL_BITS; i++) begin
			if (b_in[i]) begin
				r = r ^ a;
			end
			a = {a[SYMBOL_BITS-2:0], 1'b0} ^ (a[SYMBOL_BITS-1] ? p_in : '0);
		end
		return r;
	endfunction

	// build step multiplies the left neighbor, encoding multiplies our own coefficient
	assign mul_a = ctrl.gen_step ? alpha : fb;
	assign mul_b = ctrl.gen_step ? gen_left : gen_q;
	assign prod = gf_mul(mul_a, mul_b, poly);

	always_ff @(posedge clk) begin
		if (ctrl.gen_clear) begin
			gen_q <= '0;
		end else if (ctrl.gen_step) begin
			gen_q <= gen_q ^ prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctrl.encode) begin
			rem_q <= rem_right ^ prod;
		end else if (ctrl.shift) begin
			rem_q <= rem_right;
		end
	end

	assign gen = gen_q;
	assign rem = rem_q;

endmodule

// ===== sv/rse_out_queue.sv =====
// ---------------------------------------------------------------------------
// rse_out_queue: two-entry output queue
// Registers result items and lets the input side run while one waits.
// ---------------------------------------------------------------------------
module rse_out_queue
	import rse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  code_item_t push_item,
	output logic       full,
	output logic       room,
	output logic       code_valid,
	input  logic       code_stall,
	output code_item_t code
);

	logic [1:0] cnt_q;
	code_item_t slot0_q;
	code_item_t slot1_q;
	logic       pop;

	assign pop = (cnt_q != 2'd0) && !code_stall;
	assign full = (cnt_q == 2'd2);
	assign room = !full || pop;
	assign code_valid = (cnt_q != 2'd0);
	assign code = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1) begin
				slot0_q <= push_item;
			end else begin
				slot0_q <= slot1_q;
			end
			if (push && cnt_q == 2'd2) begin
				slot1_q <= push_item;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= push_item;
			end else begin
				slot1_q <= push_item;
			end
		end
	end

endmodule

// ===== sv/rs_systematic_encoder.sv =====
// ---------------------------------------------------------------------------
// rs_systematic_encoder: systematic Reed-Solomon encoder over GF(2^m)
//
//   channel | direction | handshake          | item
//   sym     | in        | sym_valid/stall    | message symbol, last flag
//   code    | out       | code_valid/stall   | code symbol, parity, last
//   cfg     | in        | cfg_valid/ready    | register index, data
//
// one message symbol per cycle through the chain of LFSR cells while input is not stalled
// after the last symbol the p parity items drain one per cycle while the queue has room, input stalled
// generator rebuild after reset or a register write: a clear state, then step states,
// starts only between messages, input stalled until done
// two-entry output queue, so input runs while one result waits
// ---------------------------------------------------------------------------
`include "rs_systematic_encoder_defines.svh"

module rs_systematic_encoder
	import rse_pkg::*;
#(
	parameter int SYMBOL_BITS = 8,
	parameter int MAX_PARITY = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sym_valid,
	output logic                  sym_stall,
	input  sym_item_t             sym,
	output logic                  code_valid,
	input  logic                  code_stall,
	output code_item_t            code,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW = $clog2(MAX_PARITY + 1);

	logic [7:0]             field_poly_q;
	logic [5:0]             parity_count_q;
	logic                   dirty_q;
	logic                   busy_q;
	logic [SYMBOL_BITS-1:0] act_poly_q;
	logic [PW-1:0]          act_p_q;
	logic [PW-1:0]          eff_p;
	logic [PW-1:0]          step_q;
	logic [PW-1:0]          par_cnt_q;
	logic [SYMBOL_BITS-1:0] alpha_q;
	gen_state_t             gen_state_q;
	gen_state_t             gen_next;
	logic                   gen_start;
	cell_ctrl_t             ctrl;

	logic                   cfg_wr;
	logic                   sym_acc;
	logic                   par_push;
	logic                   q_full;
	logic                   q_room;
	logic                   push;
	code_item_t             push_item;
	logic [SYMBOL_BITS-1:0] sym_s;
	logic [SYMBOL_BITS-1:0] fb;

	logic [SYMBOL_BITS-1:0] gen_w [MAX_PARITY];
	logic [SYMBOL_BITS-1:0] rem_w [MAX_PARITY];

	// configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_poly_q <= FIELD_POLY_RESET;
			parity_count_q <= PARITY_COUNT_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_FIELD_POLY: field_poly_q <= cfg_data[7:0];
				CFG_PARITY_COUNT: parity_count_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// clamp parity count to 1..MAX_PARITY
	always_comb begin
		if (parity_count_q == 6'd0) begin
			eff_p = PW'(1);
		end else if (int'(parity_count_q) > MAX_PARITY) begin
			eff_p = PW'(MAX_PARITY);
		end else begin
			eff_p = PW'(parity_count_q);
		end
	end

	// generator rebuild sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state_q <= GEN_IDLE;
		end else begin
			gen_state_q <= gen_next;
		end
	end

	always_comb begin
		gen_next = gen_state_q;
		gen_start = 1'b0;
		ctrl.encode = sym_acc;
		ctrl.shift = par_push;
		ctrl.gen_clear = 1'b0;
		ctrl.gen_step = 1'b0;
		case (gen_state_q)
			GEN_IDLE: begin
				if (dirty_q && !busy_q) begin
					gen_start = 1'b1;
					gen_next = GEN_CLEAR;
				end
			end
			GEN_CLEAR: begin
				ctrl.gen_clear = 1'b1;
				gen_next = GEN_STEP;
			end
			GEN_STEP: begin
				ctrl.gen_step = 1'b1;
				if (step_q == PW'(1)) begin
					gen_next = GEN_IDLE;
				end
			end
			default: gen_next = GEN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b1;
		end else if (cfg_wr) begin
			dirty_q <= 1'b1;
		end else if (gen_start) begin
			dirty_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_start) begin
			act_poly_q <= SYMBOL_BITS'(field_poly_q);
			act_p_q <= eff_p;
		end
		if (ctrl.gen_clear) begin
			alpha_q <= SYMBOL_BITS'(1);
			step_q <= act_p_q;
		end else if (ctrl.gen_step) begin
			alpha_q <= {alpha_q[SYMBOL_BITS-2:0], 1'b0}
				^ (alpha_q[SYMBOL_BITS-1] ? act_poly_q : '0);
			step_q <= step_q - PW'(1);
		end
	end

	// input side
	assign sym_stall = q_full || (par_cnt_q != '0)
		|| (!busy_q && (dirty_q || gen_state_q != GEN_IDLE));
	assign sym_acc = sym_valid && !sym_stall;
	assign sym_s = SYMBOL_BITS'(sym.symbol);
	assign fb = sym_s ^ rem_w[0];
	assign par_push = (par_cnt_q != '0) && q_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			par_cnt_q <= '0;
		end else begin
			if (sym_acc) begin
				busy_q <= !sym.last_symbol;
			end
			if (sym_acc && sym.last_symbol) begin
				par_cnt_q <= act_p_q;
			end else if (par_push) begin
				par_cnt_q <= par_cnt_q - PW'(1);
			end
		end
	end

	// chain of cells, remainder shifts toward cell 0
	for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
		logic [SYMBOL_BITS-1:0] left;
		logic [SYMBOL_BITS-1:0] right;
		if (j == 0) begin : g_first
			assign left = SYMBOL_BITS'(1);
		end else begin : g_inner
			assign left = gen_w[j-1];
		end
		if (j == MAX_PARITY - 1) begin : g_end
			assign right = '0;
		end else begin : g_mid
			assign right = rem_w[j+1];
		end
		rse_cell #(
			.SYMBOL_BITS(SYMBOL_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.poly     (act_poly_q),
			.fb       (fb),
			.alpha    (alpha_q),
			.gen_left (left),
			.rem_right(right),
			.gen      (gen_w[j]),
			.rem      (rem_w[j])
		);
	end

	// output side
	assign push = sym_acc || par_push;

	always_comb begin
		if (sym_acc) begin
			push_item.code_symbol = 8'(sym_s);
			push_item.is_parity = 1'b0;
			push_item.last_of_block = 1'b0;
		end else begin
			push_item.code_symbol = 8'(rem_w[0]);
			push_item.is_parity = 1'b1;
			push_item.last_of_block = (par_cnt_q == PW'(1));
		end
	end

	rse_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.room      (q_room),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code      (code)
	);

	`RSE_ASSERT(a_parity_load, (sym_acc && sym.last_symbol) |=> (par_cnt_q == $past(act_p_q)), "parity count not loaded on last symbol")
	`RSE_NEVER(a_rebuild_idle, (gen_state_q != GEN_IDLE) && busy_q, "generator rebuild during a message")
	`RSE_ASSERT(a_last_parity, (code_valid && code.last_of_block) |-> code.is_parity, "block end on a data item")

endmodule
